[sv/jls_pkg.sv]
// ============================================================================
// jls_pkg
// Shared types and constants for the Jacobi five-point stencil sweep block.
// ============================================================================
`default_nettype none

package jls_pkg;

    // Largest grid that the line store and counters support
    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_ROWS    = 1024;

    localparam int COL_W = $clog2(MAX_COLUMNS);
    localparam int ROW_W = $clog2(MAX_ROWS);

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = CFG_IDX_W'(1);

    // Smallest grid dimension that has an interior
    localparam int MIN_SIZE = 3;

    typedef logic signed [31:0] t_value;
    typedef logic        [31:0] t_error;

endpackage

`default_nettype wire

[sv/jls_ifs.sv]
// ============================================================================
// jls stream interfaces
// Valid/ready channels for grid input, stencil results and configuration.
// ============================================================================
`default_nettype none

interface jls_in_if;
    import jls_pkg::*;
    logic   valid;
    logic   ready;
    t_value cell_value;

    modport source (output valid, output cell_value, input ready);
    modport sink   (input valid, input cell_value, output ready);
endinterface

interface jls_out_if;
    import jls_pkg::*;
    logic   valid;
    logic   ready;
    t_value new_value;
    t_error max_error;
    logic   sweep_end;

    modport source (output valid, output new_value, output max_error,
                    output sweep_end, input ready);
    modport sink   (input valid, input new_value, input max_error,
                    input sweep_end, output ready);
endinterface

interface jls_cfg_if;
    import jls_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[sv/jacobi_laplace_stencil_sweep.sv]
// A request passes through stage 1 and stage 2 into the result register.
// Throughput: one grid element per cycle while results are taken; the row memory
// is read once at accept and written back as the request leaves stage 1.
// Rows 0-1 and columns 0-1 give no result. Reset clears control state and
// restores both grid sizes to the maximum; the row memory is not cleared, since
// every entry is written in a sweep before a result depends on it.
// ============================================================================
// jacobi_laplace_stencil_sweep
// Streams a Jacobi sweep of a five-point Laplace stencil in raster order,
// keeping the two rows above in one row memory and tracking the sweep's
// maximum absolute change.
// ============================================================================
`default_nettype none

module jacobi_laplace_stencil_sweep (
    input  wire         i_clk,
    input  wire         i_rst_n,
    jls_cfg_if.sink     i_cfg,
    jls_in_if.sink      i_cell,
    jls_out_if.source   o_result
);
    import jls_pkg::*;

    // Row memory: upper half holds the older row, lower half the previous row
    logic [63:0]      r_mem [MAX_COLUMNS];
    logic [63:0]      r_rd;

    logic [COL_W-1:0] r_col_last;
    logic [ROW_W-1:0] r_row_last;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    // Stage 1: memory data present, window update, 4-sum
    logic             r_s1_v;
    logic [COL_W-1:0] r_s1_addr;
    t_value           r_s1_cur;
    logic             r_s1_prod;
    logic             r_s1_end;

    t_value           r_wl;
    t_value           r_wc;
    t_value           r_above;
    t_value           r_below;

    // Stage 2: error and running maximum
    logic             r_s2_v;
    logic             r_s2_prod;
    logic             r_s2_end;
    t_value           r_s2_nv;
    t_value           r_s2_center;

    t_error           r_err_max;
    t_error           n_err_max;

    logic             r_o_v;
    t_value           r_o_nv;
    t_error           r_o_max;
    logic             r_o_end;

    logic             in_acc;
    logic             cfg_acc;
    logic             s1_adv;
    logic             s2_adv;
    logic             col_at_last;
    logic             row_at_last;
    t_value           mem_up;
    t_value           mem_mid;
    logic signed [33:0] sum4;
    logic signed [32:0] diff;
    logic signed [32:0] mag;
    t_error           err;

    assign cfg_acc = i_cfg.valid & i_cfg.ready;
    assign i_cfg.ready = 1'b1;

    // Produced items block in stage 2 only while the result register is held
    assign s2_adv = r_s2_v & (~r_s2_prod | ~r_o_v | o_result.ready);
    assign s1_adv = r_s1_v & (~r_s2_v | s2_adv);
    assign i_cell.ready = ~r_s1_v | s1_adv;
    assign in_acc = i_cell.valid & i_cell.ready;

    assign col_at_last = (r_col == r_col_last);
    assign row_at_last = (r_row == r_row_last);

    // ---------------- configuration and position counters ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_last <= COL_W'(MAX_COLUMNS - 1);
            r_row_last <= ROW_W'(MAX_ROWS - 1);
            r_col      <= '0;
            r_row      <= '0;
        end else if (cfg_acc) begin
            if (i_cfg.index == REG_GRID_COLUMNS) begin
                if (int'(i_cfg.data) < MIN_SIZE) begin
                    r_col_last <= COL_W'(MIN_SIZE - 1);
                end else if (int'(i_cfg.data) > MAX_COLUMNS) begin
                    r_col_last <= COL_W'(MAX_COLUMNS - 1);
                end else begin
                    r_col_last <= COL_W'(i_cfg.data - CFG_DATA_W'(1));
                end
                r_col <= '0;
                r_row <= '0;
            end else if (i_cfg.index == REG_GRID_ROWS) begin
                if (int'(i_cfg.data) < MIN_SIZE) begin
                    r_row_last <= ROW_W'(MIN_SIZE - 1);
                end else if (int'(i_cfg.data) > MAX_ROWS) begin
                    r_row_last <= ROW_W'(MAX_ROWS - 1);
                end else begin
                    r_row_last <= ROW_W'(i_cfg.data - CFG_DATA_W'(1));
                end
                r_col <= '0;
                r_row <= '0;
            end
        end else if (in_acc) begin
            if (col_at_last) begin
                r_col <= '0;
                r_row <= row_at_last ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // ---------------- row memory ----------------
    // The same column comes back at least three requests later, and a request
    // is taken only as the one before it leaves stage 1, so the write-back
    // always lands before the next read of that entry.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd <= r_mem[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_mem[r_s1_addr] <= {mem_mid, r_s1_cur};
        end
    end

    assign mem_up  = t_value'(r_rd[63:32]);
    assign mem_mid = t_value'(r_rd[31:0]);

    // ---------------- stage 1 ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (in_acc) begin
            r_s1_v <= 1'b1;
        end else if (s1_adv) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_addr <= r_col;
            r_s1_cur  <= i_cell.cell_value;
            r_s1_prod <= (r_row >= ROW_W'(2)) && (r_col >= COL_W'(2));
            r_s1_end  <= col_at_last & row_at_last;
        end
    end

    assign sum4 = 34'(r_wl) + 34'(mem_mid) + 34'(r_above) + 34'(r_below);

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_wl        <= r_wc;
            r_wc        <= mem_mid;
            r_above     <= mem_up;
            r_below     <= r_s1_cur;
            r_s2_prod   <= r_s1_prod;
            r_s2_end    <= r_s1_end;
            // floor of the 4-sum over four
            r_s2_nv     <= t_value'(sum4[33:2]);
            r_s2_center <= r_wc;
        end
    end

    // ---------------- stage 2 ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (s1_adv) begin
            r_s2_v <= 1'b1;
        end else if (s2_adv) begin
            r_s2_v <= 1'b0;
        end
    end

    assign diff = 33'(r_s2_nv) - 33'(r_s2_center);
    assign mag  = diff[32] ? -diff : diff;
    assign err  = t_error'(mag[31:0]);
    assign n_err_max = (err > r_err_max) ? err : r_err_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_max <= '0;
        end else if (cfg_acc && (i_cfg.index == REG_GRID_COLUMNS ||
                                 i_cfg.index == REG_GRID_ROWS)) begin
            r_err_max <= '0;
        end else if (s2_adv && r_s2_prod) begin
            // drop the maximum after the last interior point of the sweep
            r_err_max <= r_s2_end ? '0 : n_err_max;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (s2_adv && r_s2_prod) begin
            r_o_v <= 1'b1;
        end else if (o_result.ready) begin
            r_o_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv && r_s2_prod) begin
            r_o_nv  <= r_s2_nv;
            r_o_max <= n_err_max;
            r_o_end <= r_s2_end;
        end
    end

    assign o_result.valid     = r_o_v;
    assign o_result.new_value = r_o_nv;
    assign o_result.max_error = r_o_max;
    assign o_result.sweep_end = r_o_end;

endmodule

`default_nettype wire

[sv/jls_checker.sv]
// ============================================================================
// jls_checker
// Port-level checks on the stencil sweep block, bound to the top level.
// ============================================================================
`default_nettype none

module jls_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_ready,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [31:0] i_out_value,
    input wire [31:0] i_out_error,
    input wire        i_out_end
);
    import jls_pkg::*;

    // A held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_value) && $stable(i_out_error)
             && $stable(i_out_end)))
        else $error("result changed while held");

    // Nothing is presented right after reset
    a_out_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

    // The block is ready to take a request right after reset
    a_in_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> i_in_ready)
        else $error("input not ready after reset");

    // The input stalls only under back-pressure from the result side
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !i_out_ready))
        else $error("input stalled without output back-pressure");

endmodule

bind jacobi_laplace_stencil_sweep jls_checker u_jls_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_cell.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_value (o_result.new_value),
    .i_out_error (o_result.max_error),
    .i_out_end   (o_result.sweep_end)
);

`default_nettype wire

[sim/jacobi_laplace_stencil_sweep_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// jacobi_laplace_stencil_sweep_tb
// Streams grids in raster order through the five-point stencil sweep and
// checks random-grid results against a cycle-free sweep predictor: neighbor
// average, running maximum change and end-of-sweep flag. Covers small and
// extreme grid sizes, clamped sizes, writes to spare register indexes, random
// gaps on both channels and a long result hold-off that backs up the input.
// ============================================================================

module jacobi_laplace_stencil_sweep_tb;
    import jls_pkg::*;

    localparam int unsigned ITEM_TARGET      = 850;
    localparam int unsigned DRAIN_CYCLES     = 8;
    localparam int unsigned LONG_HOLD_CYCLES = 400;
    localparam int unsigned CYCLE_LIMIT      = 3_000_000;

    typedef struct packed {
        t_value new_value;
        t_error max_error;
        logic   sweep_end;
    } t_stencil_result;

    // Hand-checked expectation attached to a directed grid value
    typedef struct packed {
        logic            typed;
        logic            has_result;
        t_stencil_result result;
    } t_value_note;

    typedef enum logic {STEP_REG, STEP_VALUE} t_step_kind;

    typedef struct packed {
        t_step_kind            kind;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_data;
        t_value                grid_value;
        logic                  typed;
        logic                  has_result;
        t_stencil_result       result;
    } t_plan_row;

    localparam t_value VMAX = 32'sh7FFF_FFFF;
    localparam t_value VMIN = 32'sh8000_0000;

    // Two values at reset sizes, then two 3x3 grids: all-max neighbors around
    // a min center, and a single -1 neighbor that must round toward -inf.
    localparam t_plan_row DIRECTED [22] = '{
        '{STEP_VALUE, '0, '0, 32'sh0000_0001, 1'b1, 1'b0, '0},
        '{STEP_VALUE, '0, '0, 32'shFFFF_FFFF, 1'b1, 1'b0, '0},
        '{STEP_REG, REG_GRID_COLUMNS, 11'd3, '0, 1'b0, 1'b0, '0},
        '{STEP_REG, REG_GRID_ROWS,    11'd3, '0, 1'b0, 1'b0, '0},
        '{STEP_VALUE, '0, '0, 32'sh1234_5678, 1'b1, 1'b0, '0},
        '{STEP_VALUE, '0, '0, VMAX,           1'b1, 1'b0, '0},
        '{STEP_VALUE, '0, '0, 32'shDEAD_BEEF, 1'b1, 1'b0, '0},
        '{STEP_VALUE, '0, '0, VMAX,           1'b1, 1'b0, '0},
        '{STEP_VALUE, '0, '0, VMIN,           1'b1, 1'b0, '0},
        '{STEP_VALUE, '0, '0, VMAX,           1'b1, 1'b0, '0},
        '{STEP_VALUE, '0, '0, 32'sh0F0F_0F0F, 1'b1, 1'b0, '0},
        '{STEP_VALUE, '0, '0, VMAX,           1'b1, 1'b0, '0},
        '{STEP_VALUE, '0, '0, 32'shF0F0_F0F0, 1'b1, 1'b1,
          '{32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b1}},
        '{STEP_VALUE, '0, '0, VMAX,           1'b1, 1'b0, '0},
        '{STEP_VALUE, '0, '0, 32'shFFFF_FFFF, 1'b1, 1'b0, '0},
        '{STEP_VALUE, '0, '0, VMIN,           1'b1, 1'b0, '0},
        '{STEP_VALUE, '0, '0, 32'sh0000_0000, 1'b1, 1'b0, '0},
        '{STEP_VALUE, '0, '0, 32'sh0000_0000, 1'b1, 1'b0, '0},
        '{STEP_VALUE, '0, '0, 32'sh0000_0000, 1'b1, 1'b0, '0},
        '{STEP_VALUE, '0, '0, VMIN,           1'b1, 1'b0, '0},
        '{STEP_VALUE, '0, '0, 32'sh0000_0000, 1'b1, 1'b0, '0},
        '{STEP_VALUE, '0, '0, VMAX,           1'b1, 1'b1,
          '{32'shFFFF_FFFF, 32'h0000_0001, 1'b1}}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    jls_cfg_if cfg_ch ();
    jls_in_if  grid_ch ();
    jls_out_if result_ch ();

    jacobi_laplace_stencil_sweep i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_ch),
        .i_cell   (grid_ch),
        .o_result (result_ch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Sweep predictor state
    t_value                row_above_store [MAX_COLUMNS];
    t_value                row_prev_store  [MAX_COLUMNS];
    t_value                win_left, win_center, above_ctr, below_ctr;
    int unsigned           col_pos, row_pos;
    t_error                sweep_err_max;
    logic [CFG_DATA_W-1:0] cfg_columns, cfg_rows;

    t_stencil_result pending_results [$];
    t_value_note     value_notes [$];

    int unsigned mismatch_count  = 0;
    int unsigned values_taken    = 0;
    int unsigned results_checked = 0;
    int unsigned sweep_ends      = 0;
    int unsigned reg_writes      = 0;
    int unsigned items_sent      = 0;
    int unsigned cycle_count     = 0;
    bit          no_idle         = 1'b0;
    bit          long_hold_req   = 1'b0;

    function automatic int unsigned used_size(input logic [CFG_DATA_W-1:0] v,
                                              input int unsigned hi);
        if (v < MIN_SIZE) return MIN_SIZE;
        if (v > hi) return hi;
        return 32'(v);
    endfunction

    function automatic void restart_sweep();
        col_pos       = 0;
        row_pos       = 0;
        sweep_err_max = '0;
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] val);
        if (idx == REG_GRID_COLUMNS) begin
            cfg_columns = val;
            restart_sweep();
        end else if (idx == REG_GRID_ROWS) begin
            cfg_rows = val;
            restart_sweep();
        end
    endfunction

    // Advance the sweep by one grid value; returns 1 when an interior point
    // is updated.
    function automatic bit stencil_average(input t_value v, output t_stencil_result res);
        int unsigned       cols, rows;
        t_value            up_v, mid_v;
        logic signed [33:0] sum4, avg4, diff;
        logic [33:0]       mag;
        bit                made;
        cols = used_size(cfg_columns, MAX_COLUMNS);
        rows = used_size(cfg_rows, MAX_ROWS);
        made = 1'b0;
        res  = '0;
        up_v  = row_above_store[col_pos];
        mid_v = row_prev_store[col_pos];
        row_above_store[col_pos] = mid_v;
        row_prev_store[col_pos]  = v;
        if (row_pos >= 2 && col_pos >= 2) begin
            sum4 = win_left + mid_v + above_ctr + below_ctr;
            avg4 = sum4 >>> 2;
            diff = avg4 - win_center;
            mag  = diff[33] ? -diff : diff;
            if (mag[31:0] > sweep_err_max) sweep_err_max = mag[31:0];
            res.new_value = avg4[31:0];
            res.max_error = sweep_err_max;
            res.sweep_end = (row_pos + 1 >= rows) && (col_pos + 1 >= cols);
            made = 1'b1;
        end
        win_left   = win_center;
        win_center = mid_v;
        above_ctr  = up_v;
        below_ctr  = v;
        if (col_pos + 1 >= cols) begin
            col_pos = 0;
            if (row_pos + 1 >= rows) begin
                row_pos       = 0;
                sweep_err_max = '0;
            end else begin
                row_pos = row_pos + 1;
            end
        end else begin
            col_pos = col_pos + 1;
        end
        return made;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic t_value random_grid_value();
        case ($urandom_range(0, 9))
            0:       return VMAX;
            1:       return VMIN;
            2, 3:    return t_value'($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
            default: return t_value'($urandom());
        endcase
    endfunction

    // Sample both channels at the rising edge: predict on accepted grid
    // values, then match accepted results against the oldest expectation.
    always @(posedge i_clk) begin : scoreboard
        t_stencil_result calc;
        t_stencil_result want;
        t_value_note     note;
        bit              made;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                apply_register(cfg_ch.index, cfg_ch.data);
                reg_writes++;
            end
            if (grid_ch.valid && grid_ch.ready) begin
                note = value_notes.pop_front();
                made = stencil_average(grid_ch.cell_value, calc);
                if (note.typed) begin
                    if (note.has_result) pending_results.push_back(note.result);
                end else if (made) begin
                    pending_results.push_back(calc);
                end
                values_taken++;
            end
            if (result_ch.valid && result_ch.ready) begin
                if (pending_results.size() == 0) begin
                    $error("result with no expectation waiting: new_value %h",
                           result_ch.new_value);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (result_ch.new_value !== want.new_value) begin
                        $error("new_value: expected %h, got %h",
                               want.new_value, result_ch.new_value);
                        mismatch_count++;
                    end
                    if (result_ch.max_error !== want.max_error) begin
                        $error("max_error: expected %h, got %h",
                               want.max_error, result_ch.max_error);
                        mismatch_count++;
                    end
                    if (result_ch.sweep_end !== want.sweep_end) begin
                        $error("sweep_end: expected %b, got %b",
                               want.sweep_end, result_ch.sweep_end);
                        mismatch_count++;
                    end
                    if (want.sweep_end) sweep_ends++;
                end
                results_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, pending_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side back-pressure
    initial begin : result_ready_drive
        int unsigned stall;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                stall = no_idle ? 0 : pick_gap();
                if (stall != 0) begin
                    result_ch.ready <= 1'b0;
                    repeat (stall - 1) @(negedge i_clk);
                end else begin
                    result_ch.ready <= 1'b1;
                end
            end
        end
    end

    task automatic send_value(input t_value v, input t_value_note note);
        int unsigned gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap != 0) begin
            @(negedge i_clk);
            grid_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        value_notes.push_back(note);
        grid_ch.valid      <= 1'b1;
        grid_ch.cell_value <= v;
        @(posedge i_clk);
        while (!grid_ch.ready) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Hold the input until every expected result is in, then let border
    // values still in the pipeline retire.
    task automatic settle();
        @(negedge i_clk);
        grid_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] cols_w,
                             input logic [CFG_DATA_W-1:0] rows_w,
                             input int unsigned n_items, input bit rewrite,
                             input bit hold_results,
                             input logic [CFG_IDX_W-1:0] spare_index);
        settle();
        if (rewrite) begin
            write_reg(REG_GRID_COLUMNS, cols_w);
            write_reg(REG_GRID_ROWS, rows_w);
        end else begin
            // spare index: sweep position must carry on
            write_reg(spare_index, CFG_DATA_W'($urandom()));
        end
        no_idle = !hold_results && ($urandom_range(0, 3) == 0);
        if (hold_results) long_hold_req = 1'b1;
        repeat (n_items) send_value(random_grid_value(), '0);
    endtask

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] cols_w, rows_w;
        int unsigned           area, n_items;
        t_value_note           note;

        i_rst_n            = 1'b0;
        grid_ch.valid      = 1'b0;
        grid_ch.cell_value = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = '0;
        cfg_ch.data        = '0;
        cfg_columns        = CFG_DATA_W'(MAX_COLUMNS);
        cfg_rows           = CFG_DATA_W'(MAX_ROWS);
        win_left   = '0;
        win_center = '0;
        above_ctr  = '0;
        below_ctr  = '0;
        for (int k = 0; k < MAX_COLUMNS; k++) begin
            row_above_store[k] = '0;
            row_prev_store[k]  = '0;
        end
        restart_sweep();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[k]) begin
            if (DIRECTED[k].kind == STEP_REG) begin
                settle();
                write_reg(DIRECTED[k].reg_index, DIRECTED[k].reg_data);
            end else begin
                note.typed      = DIRECTED[k].typed;
                note.has_result = DIRECTED[k].has_result;
                note.result     = DIRECTED[k].result;
                send_value(DIRECTED[k].grid_value, note);
                items_sent++;
            end
        end

        // Partial sweep under a long result hold-off, then carry on across a
        // spare register write.
        run_phase(11'd12, 11'd10, 12 * 10 * 2 + 37, 1'b1, 1'b1, '0);
        run_phase(11'd12, 11'd10, 120, 1'b0, 1'b0, '1);
        items_sent += 12 * 10 * 2 + 37 + 120;

        // Start of the widest and tallest grids; 2047 clamps to the maximum
        run_phase(11'd2047, 11'd3, 40, 1'b1, 1'b0, '0);
        run_phase(11'd3, 11'd1024, 120, 1'b1, 1'b0, '0);
        items_sent += 40 + 120;

        while (items_sent < ITEM_TARGET) begin
            if ((col_pos != 0 || row_pos != 0) && $urandom_range(0, 2) == 0) begin
                n_items = $urandom_range(5, 60);
                if (n_items > ITEM_TARGET - items_sent) n_items = ITEM_TARGET - items_sent;
                run_phase(cfg_columns, cfg_rows, n_items, 1'b0, 1'b0,
                          CFG_IDX_W'($urandom_range(REG_GRID_ROWS + 1,
                                                    2 ** CFG_IDX_W - 1)));
            end else begin
                cols_w = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom_range(0, 2))
                                                     : CFG_DATA_W'($urandom_range(3, 12));
                rows_w = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom_range(0, 2))
                                                     : CFG_DATA_W'($urandom_range(3, 10));
                area = used_size(cols_w, MAX_COLUMNS) * used_size(rows_w, MAX_ROWS);
                n_items = area * $urandom_range(1, 3);
                // leave some sweeps unfinished so the next write restarts them
                if ($urandom_range(0, 3) == 0) n_items += $urandom_range(1, area - 1);
                if (n_items > ITEM_TARGET - items_sent) n_items = ITEM_TARGET - items_sent;
                run_phase(cols_w, rows_w, n_items, 1'b1, 1'b0, '0);
            end
            items_sent += n_items;
        end

        settle();
        $display("Took %0d grid values and %0d register writes; checked %0d results, %0d sweep ends.",
                 values_taken, reg_writes, results_checked, sweep_ends);
        $display("Grids 3x3 to 12x10, starts of 1024-wide and 1024-tall grids, clamped sizes, spare indexes, %0d-cycle hold-off.",
                 LONG_HOLD_CYCLES);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
